[hdl/size_budget_fifo_cache_tracker_top_assert.svh]
// Assertion macros shared by the tracker RTL.
// Each macro checks a property on the rising edge of clk and is disabled in reset.
`ifndef SIZE_BUDGET_FIFO_CACHE_TRACKER_TOP_ASSERT_SVH
`define SIZE_BUDGET_FIFO_CACHE_TRACKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBFCT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBFCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/sbfct_pkg.sv]
package sbfct_pkg;

	localparam int ID_W   = 12;
	localparam int SIZE_W = 40;
	localparam int CAP_W  = 48;

	localparam int ID_BITS_DEF     = 12;
	localparam int QUEUE_DEPTH_DEF = 32;

	// Upper bound on eviction beats produced by one insert.
	localparam int MAX_EVICT = 32;
	localparam int EVICT_W   = $clog2(MAX_EVICT + 1);

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 48'd8000000000000;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_FULL      = 2'd2,
		ST_EVICT     = 2'd3
	} status_t;

	typedef struct packed {
		op_t               operation;
		logic [ID_W-1:0]   item_id;
		logic [SIZE_W-1:0] item_size;
		logic              force_insert;
	} req_t;

	typedef struct packed {
		logic              present;
		status_t           status;
		logic [ID_W-1:0]   evicted_id;
		logic [SIZE_W-1:0] evicted_size;
		logic              last;
	} rsp_t;

endpackage

[hdl/sbfct_ram.sv]
module sbfct_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/size_budget_fifo_cache_tracker_top.sv]
// Size-budget FIFO cache tracker.
// Request channel (req_valid/req_ready, payload req): a lookup asks for the
// presence bit of an id; an insert queues an id with its size and evicts the
// oldest entries while the used total is above cache_capacity, unless
// force_insert is set. Response channel (rsp_valid/rsp_ready, payload rsp):
// one beat per lookup or refused insert, and for an accepted insert one
// eviction beat per evicted entry followed by an ok beat; last marks the
// final beat of each request. cfg_we/cfg_wdata write cache_capacity.
// One request is worked on at a time. A lookup's beat is registered in S_LOOK,
// using the registered read of the presence memory; a refused insert's beat
// is registered in S_INS. An accepted insert queues its entry in S_INS; each
// eviction reads the head of the order queue memory in S_CHK, then registers
// its eviction beat and retires it in S_EVRD, at most 32 evictions per insert.
// The insert's ok beat is registered in S_CHK once no further eviction is due.
// After reset the presence memory is cleared by a pass over all 2**ID_BITS
// entries (4096 by default) during which req_ready stays low; capacity writes are
// taken during the pass. A stalled receiver holds the response register and
// the sequencer waits until the beat is taken.
module size_budget_fifo_cache_tracker_top
	import sbfct_pkg::*;
#(
	parameter int ID_BITS     = ID_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int QW = ID_BITS + SIZE_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_INS,
		S_CHK,
		S_EVRD
	} state_t;

	state_t               state_q;
	logic [ID_BITS-1:0]   clr_q;
	logic [CAP_W-1:0]     cap_q;
	logic [CAP_W-1:0]     used_q;
	logic [PW-1:0]        head_q;
	logic [PW-1:0]        tail_q;
	logic [CW-1:0]        count_q;
	logic [EVICT_W-1:0]   n_q;
	req_t                 req_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 pm_we;
	logic [ID_BITS-1:0]   pm_waddr;
	logic                 pm_wdata;
	logic                 pm_re;
	logic                 pm_rdata;
	logic                 q_we;
	logic                 q_re;
	logic [QW-1:0]        q_rdata;

	logic [ID_BITS-1:0]   ins_id;
	logic [ID_BITS-1:0]   ev_id;
	logic [SIZE_W-1:0]    ev_size;
	logic                 too_large;
	logic                 full;
	logic                 ins_ok;
	logic                 evict_go;
	logic                 out_free;
	logic                 rsp_load;

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] s);
		return (s == PW'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	assign ins_id    = ID_BITS'(req_q.item_id);
	assign ev_id     = q_rdata[QW-1:SIZE_W];
	assign ev_size   = q_rdata[SIZE_W-1:0];
	assign too_large = CAP_W'(req_q.item_size) > cap_q;
	assign full      = count_q == CW'(QUEUE_DEPTH);
	assign ins_ok    = !too_large && !full;
	assign evict_go  = !req_q.force_insert && (used_q > cap_q) && (count_q != '0)
		&& (n_q != EVICT_W'(MAX_EVICT));
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_load  = out_free && ((state_q == S_LOOK) || (state_q == S_INS && !ins_ok)
		|| (state_q == S_CHK && !evict_go) || (state_q == S_EVRD));

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		pm_we    = 1'b0;
		pm_waddr = clr_q;
		pm_wdata = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				pm_we = 1'b1;
			end
			S_INS: begin
				pm_we    = ins_ok;
				pm_waddr = ins_id;
				pm_wdata = 1'b1;
			end
			S_EVRD: begin
				pm_we    = out_free;
				pm_waddr = ev_id;
			end
			default: begin
			end
		endcase
	end

	assign pm_re = (state_q == S_IDLE) && req_valid;
	assign q_we  = (state_q == S_INS) && ins_ok;
	assign q_re  = (state_q == S_CHK) && evict_go;

	sbfct_ram #(
		.WIDTH(1),
		.DEPTH(2 ** ID_BITS)
	) u_presence (
		.clk  (clk),
		.we   (pm_we),
		.waddr(pm_waddr),
		.wdata(pm_wdata),
		.re   (pm_re),
		.raddr(ID_BITS'(req.item_id)),
		.rdata(pm_rdata)
	);

	sbfct_ram #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_order (
		.clk  (clk),
		.we   (q_we),
		.waddr(tail_q),
		.wdata({ins_id, req_q.item_size}),
		.re   (q_re),
		.raddr(head_q),
		.rdata(q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cap_q       <= CAPACITY_RESET;
			used_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			n_q         <= '0;
			req_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						n_q     <= '0;
						state_q <= (req.operation == OP_INSERT) ? S_INS : S_LOOK;
					end
				end
				S_LOOK: begin
					if (out_free) begin
						rsp_q       <= '{present: pm_rdata, status: ST_OK, evicted_id: '0,
							evicted_size: '0, last: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				S_INS: begin
					if (ins_ok) begin
						used_q  <= used_q + CAP_W'(req_q.item_size);
						tail_q  <= next_slot(tail_q);
						count_q <= count_q + 1'b1;
						state_q <= S_CHK;
					end else if (out_free) begin
						rsp_q       <= '{present: 1'b0,
							status: too_large ? ST_TOO_LARGE : ST_FULL,
							evicted_id: '0, evicted_size: '0, last: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				S_CHK: begin
					if (evict_go) begin
						state_q <= S_EVRD;
					end else if (out_free) begin
						rsp_q       <= '{present: 1'b1, status: ST_OK, evicted_id: '0,
							evicted_size: '0, last: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				S_EVRD: begin
					// The head entry read in S_CHK is retired here.
					if (out_free) begin
						rsp_q       <= '{present: 1'b0, status: ST_EVICT,
							evicted_id: ID_W'(ev_id), evicted_size: ev_size, last: 1'b0};
						head_q      <= next_slot(head_q);
						count_q     <= count_q - 1'b1;
						used_q      <= used_q - CAP_W'(ev_size);
						n_q         <= n_q + 1'b1;
						state_q     <= S_CHK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "size_budget_fifo_cache_tracker_top_assert.svh"

	`SBFCT_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(QUEUE_DEPTH), "queue count above depth")
	`SBFCT_ASSERT_SAME(a_empty_used, count_q == '0, used_q == '0, "empty queue with used total")
	`SBFCT_ASSERT_SAME(a_evict_not_last, rsp_valid && rsp.status == ST_EVICT, !rsp.last,
		"eviction beat marked last")
	`SBFCT_ASSERT_NEXT(a_push_count, state_q == S_INS && ins_ok,
		count_q == $past(count_q) + 1'b1, "accepted insert did not grow the queue")

endmodule
